[rtl/sma_pkg.sv]
// ----------------------------------------------------------------------------
// sma_pkg: shared definitions for the stack machine arithmetic block
// Field widths, opcodes, status codes and the adder request/response types.
// ----------------------------------------------------------------------------
package sma_pkg;

   localparam int DATA_W          = 32;
   localparam int KIND_W          = 3;
   localparam int STATUS_W        = 2;
   localparam int DEPTH_W         = 7;
   localparam int STACK_DEPTH_DEF = 64;

   // response tdata: status, top value, depth, zero padded to whole bytes
   localparam int RSP_FIELDS_W    = STATUS_W + DATA_W + DEPTH_W;
   localparam int RSP_TDATA_W     = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W       = RSP_TDATA_W - RSP_FIELDS_W;

   // adder operands carry one extra bit for the divider's trial subtract
   localparam int ALU_W           = DATA_W + 1;

   localparam logic [KIND_W-1:0] KIND_PUSH = 3'd0;
   localparam logic [KIND_W-1:0] KIND_SWAP = 3'd1;
   localparam logic [KIND_W-1:0] KIND_ADD  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_SUB  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_DIV  = 3'd4;
   localparam logic [KIND_W-1:0] KIND_NOP  = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_SHORT   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_DIVZERO = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

   typedef struct packed {
      logic [ALU_W-1:0] a;
      logic [ALU_W-1:0] b;
      logic             sub;
   } alu_req_type;

   typedef struct packed {
      logic [ALU_W-1:0] res;
      logic             carry;
   } alu_rsp_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

[rtl/stack_machine_arith_ops.sv]
// ----------------------------------------------------------------------------
// stack_machine_arith_ops: operand stack with push, swap, add, sub and div
// Sequencer over a stack RAM, a cached top register and one shared adder.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one opcode per transfer: req_tuser holds the kind
//   (0 push, 1 swap, 2 add, 3 sub, 4 div, 5 nop, others act as nop) and
//   req_tdata the value to push. Each opcode yields one response transfer
//   on rsp_* with status, value on top (zero when empty) and depth.
//   Errors (too few entries, zero divisor, push onto a full stack) leave
//   the stack untouched and only report a status.
// Sequence, from accepting one opcode to accepting the next:
//   push, nop and errors go from idle straight to finish; swap, add and sub
//   pass through load first; div passes through load and then divide, where the
//   divider takes one quotient bit per cycle through the shared adder.
//   req_tready is high only while the sequencer is idle.
// Stalls: the response sits in an output register, so the next opcode is
//   accepted while a response waits; its own response is held back in the
//   sequencer until the register is free.
// Reset: synchronous, active high; the stack is empty afterwards, and the
//   stack RAM needs no clearing since only written entries are read.
// ----------------------------------------------------------------------------
module stack_machine_arith_ops
   import sma_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [DATA_W-1:0]      req_tdata,  // [31:0] push_value
   input  logic [KIND_W-1:0]      req_tuser,  // [2:0] kind
   // response channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata   // [1:0] status, [33:2] top_value,
                                              // [40:34] depth, rest zero
);

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_LOAD   = 4'b0010,
      S_DIVIDE = 4'b0100,
      S_FINISH = 4'b1000
   } state_type;

   state_type             state_ff,  state_in;
   logic [CW-1:0]         count_ff,  count_in;
   logic [DATA_W-1:0]     top_ff,    top_in;     // cached top of stack
   logic [KIND_W-1:0]     kind_ff,   kind_in;
   logic [STATUS_W-1:0]   status_ff, status_in;

   logic                  rsp_valid_ff,  rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0]     rsp_top_ff,    rsp_top_in;
   logic [DEPTH_W-1:0]    rsp_depth_ff,  rsp_depth_in;

   logic                  req_xfer;
   logic                  full;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [DATA_W-1:0]     wr_data;
   logic [AW-1:0]         rd_addr;
   logic [DATA_W-1:0]     second;                // entry below the top

   alu_req_type           alu_req, op_alu_req, div_alu_req;
   alu_rsp_type           alu_rsp;
   logic                  div_start;
   div_status_type        div_status;
   logic [DATA_W-1:0]     div_quotient;

   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign full       = (count_ff == CW'(STACK_DEPTH));

   // entry below the top lives at count-2; top itself is held in top_ff
   assign rd_addr = AW'(count_ff - CW'(2));

   sma_ram #(
      .WIDTH (DATA_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (second)
   );

   // add/sub operands, used in the load step
   assign op_alu_req.a   = {1'b0, second};
   assign op_alu_req.b   = {1'b0, top_ff};
   assign op_alu_req.sub = (kind_ff == KIND_SUB);

   assign alu_req = (state_ff == S_DIVIDE) ? div_alu_req : op_alu_req;

   sma_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   sma_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (second),
      .divisor  (top_ff),
      .alu_req  (div_alu_req),
      .alu_rsp  (alu_rsp),
      .status   (div_status),
      .quotient (div_quotient)
   );

   // sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      top_in        = top_ff;
      kind_in       = kind_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_top_in    = rsp_top_ff;
      rsp_depth_in  = rsp_depth_ff;
      wr_en         = 1'b0;
      wr_addr       = AW'(count_ff - CW'(1));
      wr_data       = top_ff;
      div_start     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               kind_in   = req_tuser;
               status_in = ST_OK;
               state_in  = S_FINISH;
               unique case (req_tuser)
                  KIND_PUSH: begin
                     if (full) begin
                        status_in = ST_FULL;
                     end else begin
                        // old top spills into the RAM
                        wr_en    = (count_ff != '0);
                        top_in   = req_tdata;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  KIND_SWAP, KIND_ADD, KIND_SUB, KIND_DIV: begin
                     priority if (count_ff < CW'(2)) begin
                        status_in = ST_SHORT;
                     end else if (req_tuser == KIND_DIV && top_ff == '0) begin
                        status_in = ST_DIVZERO;
                     end else begin
                        state_in = S_LOAD;   // RAM read of second in flight
                     end
                  end
                  default: begin
                     status_in = ST_OK;
                  end
               endcase
            end
         end

         S_LOAD: begin
            unique case (kind_ff)
               KIND_SWAP: begin
                  wr_en    = 1'b1;
                  wr_addr  = rd_addr;
                  top_in   = second;
                  state_in = S_FINISH;
               end
               KIND_DIV: begin
                  div_start = 1'b1;
                  state_in  = S_DIVIDE;
               end
               default: begin         // add, sub
                  top_in   = alu_rsp.res[DATA_W-1:0];
                  count_in = count_ff - 1'b1;
                  state_in = S_FINISH;
               end
            endcase
         end

         S_DIVIDE: begin
            if (div_status.done) begin
               top_in   = div_quotient;
               count_in = count_ff - 1'b1;
               state_in = S_FINISH;
            end
         end

         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_top_in    = (count_ff != '0) ? top_ff : '0;
               rsp_depth_in  = DEPTH_W'(count_ff);
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      top_ff        <= top_in;
      kind_ff       <= kind_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_top_ff    <= rsp_top_in;
      rsp_depth_ff  <= rsp_depth_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_depth_ff, rsp_top_ff, rsp_status_ff};

`ifndef SYNTH
   // depth never passes the stack size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(STACK_DEPTH))
      else $error("stack count beyond stack size");

   // while dividing, the divider is running or has just finished
   a_div_alive: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIVIDE) |-> (div_status.busy || div_status.done))
      else $error("sequencer waits on an idle divider");

   // a pending response is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && rsp_valid_ff && !rsp_tready) |=> (state_ff == S_FINISH))
      else $error("response register overwritten");

   // a successful push raises the depth by one
   a_push_depth: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_tuser == KIND_PUSH && !full)
         |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("push did not grow the stack");
`endif

endmodule

[rtl/sma_ram.sv]
// ----------------------------------------------------------------------------
// sma_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sma_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/sma_alu.sv]
// ----------------------------------------------------------------------------
// sma_alu: shared adder/subtractor
// Used for add and sub, and for every trial subtract of the divider.
// ----------------------------------------------------------------------------
module sma_alu
   import sma_pkg::*;
(
   input  alu_req_type req,
   output alu_rsp_type rsp
);

   logic [ALU_W-1:0] b_eff;
   logic [ALU_W:0]   sum;

   assign b_eff = req.sub ? ~req.b : req.b;
   assign sum   = {1'b0, req.a} + {1'b0, b_eff} + {{ALU_W{1'b0}}, req.sub};

   // for a subtract, carry set means a >= b (unsigned)
   assign rsp.res   = sum[ALU_W-1:0];
   assign rsp.carry = sum[ALU_W];

endmodule

[rtl/sma_div.sv]
// ----------------------------------------------------------------------------
// sma_div: signed divider, one quotient bit per cycle
// Restoring division on magnitudes, trial subtract through the shared adder;
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
module sma_div
   import sma_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [DATA_W-1:0]   dividend,
   input  logic [DATA_W-1:0]   divisor,
   output alu_req_type         alu_req,
   input  alu_rsp_type         alu_rsp,
   output div_status_type      status,
   output logic [DATA_W-1:0]   quotient
);

   localparam int CNT_W = $clog2(DATA_W);

   logic [DATA_W-1:0] rem_ff,  rem_in;
   logic [DATA_W-1:0] quo_ff,  quo_in;
   logic [DATA_W-1:0] mt_ff,   mt_in;
   logic [CNT_W-1:0]  cnt_ff,  cnt_in;
   logic              neg_ff,  neg_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [ALU_W-1:0]  trial;

   // shift the next dividend bit into the partial remainder
   assign trial       = {rem_ff, quo_ff[DATA_W-1]};
   assign alu_req.a   = trial;
   assign alu_req.b   = {1'b0, mt_ff};
   assign alu_req.sub = 1'b1;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      mt_in   = mt_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
         mt_in   = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
         neg_in  = dividend[DATA_W-1] ^ divisor[DATA_W-1];
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = alu_rsp.carry ? alu_rsp.res[DATA_W-1:0] : trial[DATA_W-1:0];
         quo_in = {quo_ff[DATA_W-2:0], alu_rsp.carry};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DATA_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      mt_ff  <= mt_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = neg_ff ? (~quo_ff + 1'b1) : quo_ff;

endmodule

[tb/sv/tb_stack_machine_arith_ops.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stack_machine_arith_ops: self-checking bench for the operand stack unit
// Drives opcodes over the request stream, expects each response from the directed
// table or a behavioural copy of the stack and compares status, top value and depth.
// A directed table covers the corner cases. Randomised traffic follows, run
// under several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module tb_stack_machine_arith_ops;
   import sma_pkg::*;

   localparam int STACK_DEPTH = STACK_DEPTH_DEF;
   localparam int CLK_HALF    = 5;
   localparam int RUN_LIMIT   = 1_000_000;   // cycles, far beyond the slowest legal run
   localparam int PHASE_ITEMS = 500;
   localparam int NUM_PHASES  = 4;
   localparam int PRINT_CAP   = 200;

   // kinds 6 and 7 have no opcode of their own and behave as nop
   localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
   localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

   // idling per phase, in percent of cycles: none, sender, receiver, both
   localparam int SEND_IDLE [NUM_PHASES] = '{0, 81, 0, 14};
   localparam int RSP_STALL [NUM_PHASES] = '{0, 0, 81, 14};

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [DATA_W-1:0]   top;
      logic [DEPTH_W-1:0]  depth;
   } op_result_t;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [DATA_W-1:0] value;
      logic              typed;   // expectation below is used instead of the predictor
      op_result_t        result;
   } stim_row_t;

   localparam op_result_t NO_EXP = '{ST_OK, 32'h0, 7'd0};
   localparam int NUM_DIRECTED = 24;

   // Directed opcodes. Non-push rows carry junk in the value field, which must be ignored.
   localparam stim_row_t DIRECTED_OPS [NUM_DIRECTED] = '{
      // empty stack: two-operand ops are too short
      '{KIND_SWAP, 32'h1234_5678, 1'b1, '{ST_SHORT, 32'h0000_0000, 7'd0}},
      '{KIND_ADD,  32'hFFFF_FFFF, 1'b1, '{ST_SHORT, 32'h0000_0000, 7'd0}},
      '{KIND_PUSH, 32'h7FFF_FFFF, 1'b1, '{ST_OK,    32'h7FFF_FFFF, 7'd1}},
      // one entry: still too short
      '{KIND_SUB,  32'hA5A5_A5A5, 1'b1, '{ST_SHORT, 32'h7FFF_FFFF, 7'd1}},
      '{KIND_DIV,  32'h0000_0000, 1'b1, '{ST_SHORT, 32'h7FFF_FFFF, 7'd1}},
      '{KIND_PUSH, 32'h0000_0001, 1'b1, '{ST_OK,    32'h0000_0001, 7'd2}},
      // max positive plus one wraps
      '{KIND_ADD,  32'h5A5A_5A5A, 1'b1, '{ST_OK,    32'h8000_0000, 7'd1}},
      '{KIND_PUSH, 32'hFFFF_FFFF, 1'b1, '{ST_OK,    32'hFFFF_FFFF, 7'd2}},
      // most negative over minus one wraps to itself
      '{KIND_DIV,  32'h0000_0000, 1'b1, '{ST_OK,    32'h8000_0000, 7'd1}},
      '{KIND_PUSH, 32'h0000_0000, 1'b1, '{ST_OK,    32'h0000_0000, 7'd2}},
      // zero divisor leaves the stack alone
      '{KIND_DIV,  32'hFFFF_FFFF, 1'b1, '{ST_DIVZERO, 32'h0000_0000, 7'd2}},
      '{KIND_SWAP, 32'h0000_0000, 1'b1, '{ST_OK,    32'h8000_0000, 7'd2}},
      // zero minus most negative wraps
      '{KIND_SUB,  32'h0000_0000, 1'b1, '{ST_OK,    32'h8000_0000, 7'd1}},
      '{KIND_NOP,  32'hFFFF_FFFF, 1'b1, '{ST_OK,    32'h8000_0000, 7'd1}},
      '{KIND_SPARE_LO, 32'h0000_0000, 1'b1, '{ST_OK, 32'h8000_0000, 7'd1}},
      '{KIND_SPARE_HI, 32'hFFFF_FFFF, 1'b1, '{ST_OK, 32'h8000_0000, 7'd1}},
      '{KIND_PUSH, 32'hFFFF_FFF9, 1'b1, '{ST_OK,    32'hFFFF_FFF9, 7'd2}},
      '{KIND_PUSH, 32'h0000_0002, 1'b1, '{ST_OK,    32'h0000_0002, 7'd3}},
      // truncation toward zero with mixed and equal signs
      '{KIND_DIV,  32'h0000_0000, 1'b0, NO_EXP},
      '{KIND_PUSH, 32'hFFFF_FFFE, 1'b1, '{ST_OK,    32'hFFFF_FFFE, 7'd3}},
      '{KIND_DIV,  32'h0000_0000, 1'b0, NO_EXP},
      '{KIND_PUSH, 32'h0000_0005, 1'b1, '{ST_OK,    32'h0000_0005, 7'd3}},
      '{KIND_SUB,  32'h0000_0000, 1'b0, NO_EXP},
      '{KIND_SWAP, 32'h0000_0000, 1'b0, NO_EXP}
   };

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [DATA_W-1:0]      req_tdata = '0;    // [31:0] push_value
   logic [KIND_W-1:0]      req_tuser = KIND_NOP;   // [2:0] kind
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;         // [1:0] status, [33:2] top, [40:34] depth

   // behavioural copy of the stack
   logic [DATA_W-1:0] stack_words [STACK_DEPTH];
   int                stack_fill;
   int                depth_goal;

   op_result_t pending_results [$];
   int         mismatch_count = 0;
   int         cycle_count    = 0;
   int         send_idle_pct  = 0;
   int         rsp_stall_pct  = 0;

   always #CLK_HALF clock = ~clock;

   stack_machine_arith_ops #(
      .STACK_DEPTH (STACK_DEPTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // ------------------------------------------------------------------------
   // Predictor: applies one opcode to the stack copy, returns the response
   // ------------------------------------------------------------------------
   function automatic logic [DATA_W-1:0] signed_quotient(input logic [DATA_W-1:0] num,
                                                         input logic [DATA_W-1:0] den);
      logic [DATA_W-1:0] mag_n;
      logic [DATA_W-1:0] mag_d;
      logic [DATA_W-1:0] quo;
      mag_n = num[DATA_W-1] ? -num : num;
      mag_d = den[DATA_W-1] ? -den : den;
      quo   = mag_n / mag_d;
      return (num[DATA_W-1] ^ den[DATA_W-1]) ? -quo : quo;
   endfunction

   function automatic op_result_t apply_stack_op(input logic [KIND_W-1:0] kind,
                                                 input logic [DATA_W-1:0] value);
      op_result_t        res;
      logic [DATA_W-1:0] top_w;
      logic [DATA_W-1:0] sec_w;
      res.status = ST_OK;
      case (kind)
         KIND_PUSH: begin
            if (stack_fill >= STACK_DEPTH) begin
               res.status = ST_FULL;
            end else begin
               stack_words[stack_fill] = value;
               stack_fill++;
            end
         end
         KIND_SWAP, KIND_ADD, KIND_SUB, KIND_DIV: begin
            if (stack_fill < 2) begin
               res.status = ST_SHORT;
            end else begin
               top_w = stack_words[stack_fill-1];
               sec_w = stack_words[stack_fill-2];
               if (kind == KIND_SWAP) begin
                  stack_words[stack_fill-1] = sec_w;
                  stack_words[stack_fill-2] = top_w;
               end else if (kind == KIND_DIV && top_w == '0) begin
                  res.status = ST_DIVZERO;
               end else begin
                  case (kind)
                     KIND_ADD: stack_words[stack_fill-2] = sec_w + top_w;
                     KIND_SUB: stack_words[stack_fill-2] = sec_w - top_w;
                     default:  stack_words[stack_fill-2] = signed_quotient(sec_w, top_w);
                  endcase
                  stack_fill--;
               end
            end
         end
         default: ;   // nop and the spare kinds
      endcase
      res.top   = (stack_fill > 0) ? stack_words[stack_fill-1] : '0;
      res.depth = DEPTH_W'(stack_fill);
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // Random stimulus helpers
   // ------------------------------------------------------------------------
   // bias towards zero, small magnitudes and the extremes, else full range
   function automatic logic [DATA_W-1:0] pick_value();
      case ($urandom_range(7))
         0:       return '0;
         1:       return DATA_W'($urandom_range(32)) - DATA_W'(16);
         2:       return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         3:       return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0001;
         default: return $urandom;
      endcase
   endfunction

   // pushes dominate below the depth goal, arithmetic above it
   function automatic logic [KIND_W-1:0] pick_kind();
      int roll;
      roll = $urandom_range(99);
      if (roll < ((stack_fill < depth_goal) ? 65 : 15))
         return KIND_PUSH;
      case ($urandom_range(19))
         0, 1, 2, 3:         return KIND_SWAP;
         4, 5, 6, 7:         return KIND_ADD;
         8, 9, 10, 11:       return KIND_SUB;
         12, 13, 14, 15, 16: return KIND_DIV;
         17:                 return KIND_NOP;
         18:                 return KIND_SPARE_LO;
         default:            return KIND_SPARE_HI;
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Request side: one transfer per call, optional idle cycles ahead of it.
   // Handshake signals are read straight after the edge, i.e. pre-edge values.
   // ------------------------------------------------------------------------
   task automatic send_op(input logic [KIND_W-1:0] kind, input logic [DATA_W-1:0] value,
                          input logic typed, input op_result_t typed_res);
      op_result_t predicted;
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      // transfer accepted at this edge; stack copy always advances
      predicted = apply_stack_op(kind, value);
      pending_results.push_back(typed ? typed_res : predicted);
   endtask

   // sender holds off until every outstanding response has come back
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Response side
   // ------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                  input logic [DATA_W-1:0] want);
      if (mismatch_count < PRINT_CAP)
         $display("%0t: mismatch on %s: got 0x%h, expected 0x%h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   task automatic check_response(input logic [RSP_TDATA_W-1:0] data);
      op_result_t want;
      op_result_t got;
      got.status = data[STATUS_W-1:0];
      got.top    = data[STATUS_W +: DATA_W];
      got.depth  = data[STATUS_W+DATA_W +: DEPTH_W];
      if (pending_results.size() == 0) begin
         report_mismatch("unexpected response", DATA_W'(data), '0);
      end else begin
         want = pending_results.pop_front();
         if (got.status !== want.status)
            report_mismatch("status", DATA_W'(got.status), DATA_W'(want.status));
         if (got.top !== want.top)
            report_mismatch("top value", got.top, want.top);
         if (got.depth !== want.depth)
            report_mismatch("depth", DATA_W'(got.depth), DATA_W'(want.depth));
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         check_response(rsp_tdata);
      rsp_tready <= (rsp_stall_pct == 0) || ($urandom_range(99) >= rsp_stall_pct);
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      stack_fill = 0;
      depth_goal = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed corner cases, no idling
      for (int i = 0; i < NUM_DIRECTED; i++)
         send_op(DIRECTED_OPS[i].kind, DIRECTED_OPS[i].value,
                 DIRECTED_OPS[i].typed, DIRECTED_OPS[i].result);

      // fill to the brim and keep pushing to hit the full-stack error
      for (int i = 0; i < STACK_DEPTH + 3; i++)
         send_op(KIND_PUSH, pick_value(), 1'b0, NO_EXP);
      drain_responses();

      // random traffic, one idling pattern per phase, drained in between
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         send_idle_pct = SEND_IDLE[ph];
         rsp_stall_pct = RSP_STALL[ph];
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 120 == 0)
               depth_goal = ($urandom_range(3) == 0) ? STACK_DEPTH + 4
                                                     : $urandom_range(STACK_DEPTH);
            send_op(pick_kind(), pick_value(), 1'b0, NO_EXP);
         end
         drain_responses();
      end

      // settle for longer than a divide, catching any stray responses
      rsp_stall_pct = 0;
      repeat (64) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

[stack_machine_arith_ops.f]
rtl/sma_pkg.sv
rtl/sma_ram.sv
rtl/sma_alu.sv
rtl/sma_div.sv
rtl/stack_machine_arith_ops.sv
tb/sv/tb_stack_machine_arith_ops.sv
